[src/hsfc_pkg.sv]
`timescale 1ns / 1ps
// hsfc_pkg: widths, command codes, format constants and conversion functions
// for the half/single float converter. No dependencies.

package hsfc_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;

    typedef enum logic [0:0] {
        CMD_S2H = 1'b0,
        CMD_H2S = 1'b1
    } cmd_t;

    localparam logic [7:0]  SGL_SAT_EXP  = 8'd143;
    localparam logic [7:0]  SGL_DEN_TOP  = 8'd112;
    localparam logic [7:0]  SGL_DEN_LOW  = 8'd102;
    localparam logic [7:0]  SGL_SHIFT_BASE = 8'd126;
    localparam logic [7:0]  SGL_DENORM_BASE = 8'd103;
    localparam logic [7:0]  SGL_MAX_EXP  = 8'd142;
    localparam logic [22:0] SGL_MAX_MAN  = 23'd8380416;
    localparam logic [4:0]  HALF_EXP_ALL = 5'd31;
    localparam logic [14:0] HALF_MAX_MAG = 15'h7BFF;

    function automatic logic [DATA_W-1:0] single_to_half(input logic [DATA_W-1:0] x);
        logic        sign;
        logic [7:0]  exp;
        logic [23:0] full;
        logic [4:0]  sh;
        logic [23:0] shifted;
        logic        rnd;
        logic [14:0] mag;
        sign = x[31];
        exp  = x[30:23];
        full = {1'b1, x[22:0]};
        sh   = 5'(SGL_SHIFT_BASE - exp);
        shifted = full >> sh;
        rnd  = full[5'(sh - 5'd1)];
        if (exp <= SGL_DEN_TOP) begin
            if (exp >= SGL_DEN_LOW) begin
                mag = 15'({5'd0, shifted[9:0]}) + 15'(rnd);
            end else begin
                mag = '0;
            end
        end else if (exp >= SGL_SAT_EXP) begin
            mag = HALF_MAX_MAG;
        end else begin
            mag = {5'(exp - SGL_DEN_TOP), x[22:13]};
        end
        return {16'd0, sign, mag};
    endfunction

    function automatic logic [DATA_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
        logic        sign;
        logic [4:0]  exp;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [7:0]  e32;
        logic [22:0] m32;
        logic [32:0] wide;
        sign = h[15];
        exp  = h[14:10];
        man  = h[9:0];
        p    = '0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                p = 4'(i);
            end
        end
        // leading one lands on the hidden bit 23 and drops out below
        wide = 33'({man, 13'd0}) << (4'd10 - p);
        if (exp == 5'd0) begin
            if (man == 10'd0) begin
                e32 = '0;
                m32 = '0;
            end else begin
                e32 = SGL_DENORM_BASE + 8'(p);
                m32 = wide[22:0];
            end
        end else if (exp == HALF_EXP_ALL) begin
            e32 = SGL_MAX_EXP;
            m32 = SGL_MAX_MAN;
        end else begin
            e32 = 8'(exp) + SGL_DEN_TOP;
            m32 = {man, 13'd0};
        end
        return {sign, e32, m32};
    endfunction

endpackage

[src/half_single_float_converter_core.sv]
`timescale 1ns / 1ps
// half_single_float_converter_core: stream converter between single and half
// float bit patterns. Depends on hsfc_pkg.
//
// Usage:
//   Input stream s_axis_*: tdata carries the operand bits (half in bits 15..0),
//   tuser carries the command (0 single to half, 1 half to single).
//   Output stream m_axis_*: tdata carries the result bits; half results are
//   zero-extended in bits 31..16. One result per input transfer, in order.
//   Path: input register, then the conversion, then the result register that
//   drives m_axis_tvalid. Throughput: one transfer per cycle while not
//   stalled by m_axis_tready; set by the single conversion stage.
//   Stall: while m_axis_tready is low the result register holds, the input
//   register can still fill, and s_axis_tready drops only when both are full.
//   Reset: synchronous on aresetn low; both valid flags clear, nothing is lost
//   except items in flight, and s_axis_tready comes up high.

module half_single_float_converter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hsfc_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] operand_bits
    input  logic [0:0]                    s_axis_tuser,  // [0] command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hsfc_pkg::DATA_W-1:0]   m_axis_tdata   // [31:0] result_bits
);
    import hsfc_pkg::*;

    logic              in_vld_reg;
    logic              in_vld_next;
    cmd_t              in_cmd_reg;
    logic [DATA_W-1:0] in_bits_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [DATA_W-1:0] out_bits_reg;
    logic [DATA_W-1:0] conv;
    logic              out_free;
    logic              in_take;
    logic              advance;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (in_cmd_reg)
            CMD_S2H: conv = single_to_half(in_bits_reg);
            CMD_H2S: conv = half_to_single(in_bits_reg[HALF_W-1:0]);
            default: conv = '0;
        endcase
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_axis_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
            in_bits_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_bits_reg <= conv;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_bits_reg;

endmodule

[src/hsfc_checker.sv]
`timescale 1ns / 1ps
// hsfc_checker: port-level timing checks for half_single_float_converter_core,
// bound to the top level below. Depends on hsfc_pkg for widths.

module hsfc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [hsfc_pkg::DATA_W-1:0]   m_axis_tdata
);
    import hsfc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a rising result valid follows an input transfer via both registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching input transfer");

    // output side empty or being read never blocks the input
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output can move");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("valid result after reset");

endmodule

bind half_single_float_converter_core hsfc_checker u_hsfc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
